[sv/mma_pkg.sv]
// Shared types and constants for the multichannel moving average block.
// Holds field widths, the reciprocal table used for the mean, and the
// command and status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

   localparam int SENSOR_W = 2;
   localparam int MEAS_W   = 1;
   localparam int RANGE_W  = 18;
   localparam int AMP_W    = 16;
   localparam int COUNT_W  = 3;

   // Reciprocal multiply: floor(n / c) = (n * ceil(2^27 / c)) >> 27, exact for
   // n < 2^22 and c <= 16 since n * c stays below 2^27.
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 28;
   localparam int RECIP_IDX_W = 4;
   localparam int MUL_IN_W    = 22;
   localparam int PROD_W      = MUL_IN_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_TABLE [0:15] = '{
      28'd134217728, 28'd67108864, 28'd44739243, 28'd33554432,
      28'd26843546,  28'd22369622, 28'd19173962, 28'd16777216,
      28'd14913081,  28'd13421773, 28'd12201612, 28'd11184811,
      28'd10324441,  28'd9586981,  28'd8947849,  28'd8388608
   };

   typedef struct packed {
      logic [RANGE_W-1:0] range_val;
      logic [AMP_W-1:0]   amp_val;
   } ring_word_type;

   typedef struct packed {
      logic accept;      // latch the incoming item and read channel state
      logic update;      // store sample, advance index and fill count
      logic read;        // read one ring slot
      logic mul_range;   // multiply range sum by reciprocal
      logic mul_amp;     // multiply amplitude sum by reciprocal
      logic load_out;    // move the means into the output register
   } mma_cmd_type;

   typedef struct packed {
      logic last_slot;   // slot being read is the last filled one
      logic out_busy;    // output register holds an item not yet taken
   } mma_status_type;

endpackage

`default_nettype wire

[sv/mma_if.sv]
// Valid/ready channel interfaces for the request and response items.
// Depends on mma_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface mma_req_if import mma_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SENSOR_W-1:0] sensor_index;
   logic [MEAS_W-1:0]   measurement_index;
   logic [RANGE_W-1:0]  range_fixed;
   logic [AMP_W-1:0]    amplitude;

   modport source (output valid, sensor_index, measurement_index, range_fixed, amplitude,
                   input ready);
   modport sink   (input valid, sensor_index, measurement_index, range_fixed, amplitude,
                   output ready);
endinterface

interface mma_rsp_if import mma_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] mean_range;
   logic [AMP_W-1:0]   mean_amplitude;
   logic [COUNT_W-1:0] fill_count;

   modport source (output valid, mean_range, mean_amplitude, fill_count, input ready);
   modport sink   (input valid, mean_range, mean_amplitude, fill_count, output ready);
endinterface

`default_nettype wire

[sv/mma_ctrl.sv]
// Controller state machine for the moving average block.
// Sequences accept, update, ring sum, reciprocal multiply and output load.
// Depends on mma_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mma_ctrl import mma_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire mma_status_type status,
   output mma_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_META  = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_MUL_R = 3'd4;
   localparam logic [2:0] ST_MUL_A = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd           = '0;
      cmd.accept    = req_ready && req_valid;
      cmd.update    = (state_ff == ST_META);
      cmd.read      = (state_ff == ST_SUM);
      cmd.mul_range = (state_ff == ST_MUL_R);
      cmd.mul_amp   = (state_ff == ST_MUL_A);
      cmd.load_out  = (state_ff == ST_FIN) && !status.out_busy;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_META;
         end
         ST_META:  state_in = ST_SUM;
         ST_SUM: begin
            if (status.last_slot) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_FIN;
         ST_FIN: begin
            // hold until the previous result has been taken
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/mma_datapath.sv]
// Datapath of the moving average block: channel state memory, sample ring
// memory, serial accumulator, shared reciprocal multiplier and output register.
// Depends on mma_pkg for widths, the reciprocal table and the control structs.
`timescale 1ns / 1ps
`default_nettype none

module mma_datapath import mma_pkg::*; #(
   parameter int SENSORS      = 4,
   parameter int MEASUREMENTS = 2,
   parameter int WINDOW       = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mma_cmd_type         cmd,
   output mma_status_type           status,
   input  wire logic [SENSOR_W-1:0] sensor_index,
   input  wire logic [MEAS_W-1:0]   measurement_index,
   input  wire logic [RANGE_W-1:0]  range_fixed,
   input  wire logic [AMP_W-1:0]    amplitude,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [RANGE_W-1:0]       mean_range,
   output logic [AMP_W-1:0]         mean_amplitude,
   output logic [COUNT_W-1:0]       fill_count
);

   localparam int CHANNELS = SENSORS * MEASUREMENTS;
   localparam int DEPTH    = CHANNELS * WINDOW;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int META_W   = IDX_W + CNT_W;
   localparam int SUM_R_W  = RANGE_W + $clog2(WINDOW);
   localparam int SUM_A_W  = AMP_W + $clog2(WINDOW);

   // channel state memory plus per-channel valid bits cleared by reset
   logic [META_W-1:0]   meta_mem [0:CHANNELS-1];
   logic [META_W-1:0]   meta_rd_ff;
   logic [CHANNELS-1:0] chan_valid_ff;

   ring_word_type       ring_mem [0:DEPTH-1];
   ring_word_type       ring_rd_ff;

   logic [CH_W-1:0]     ch_in;
   logic [CH_W-1:0]     ch_ff;
   logic [RANGE_W-1:0]  range_ff;
   logic [AMP_W-1:0]    amp_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [ADDR_W-1:0]   base_in;
   logic [IDX_W-1:0]    slot_ff;
   logic                acc_pend_ff;
   logic [SUM_R_W-1:0]  sum_r_ff;
   logic [SUM_A_W-1:0]  sum_a_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [RANGE_W-1:0]  mean_r_ff;

   logic [IDX_W-1:0]    cur_idx;
   logic [CNT_W-1:0]    cur_fill;
   logic [IDX_W-1:0]    new_idx;
   logic [CNT_W-1:0]    new_fill;
   logic [MUL_IN_W-1:0] mul_op;
   logic [RECIP_W-1:0]  recip;

   logic                rsp_valid_ff;
   logic [RANGE_W-1:0]  rsp_range_ff;
   logic [AMP_W-1:0]    rsp_amp_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // reduce selectors modulo their channel counts, then form the channel number
   always_comb begin
      int s_v;
      int m_v;
      s_v = int'(sensor_index);
      m_v = int'(measurement_index);
      for (int k = 0; k < 3; k++) begin
         if (s_v >= SENSORS) s_v = s_v - SENSORS;
      end
      if (m_v >= MEASUREMENTS) m_v = m_v - MEASUREMENTS;
      ch_in = CH_W'(s_v * MEASUREMENTS + m_v);
   end

   always_comb begin
      if (chan_valid_ff[ch_ff]) begin
         cur_idx  = meta_rd_ff[META_W-1:CNT_W];
         cur_fill = meta_rd_ff[CNT_W-1:0];
      end else begin
         cur_idx  = '0;
         cur_fill = '0;
      end
      new_idx  = (cur_idx == IDX_W'(WINDOW - 1)) ? '0 : cur_idx + IDX_W'(1);
      new_fill = (cur_fill < CNT_W'(WINDOW)) ? cur_fill + CNT_W'(1) : cur_fill;
      base_in  = ADDR_W'(int'(ch_ff) * WINDOW);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         meta_rd_ff <= meta_mem[ch_in];
         ch_ff      <= ch_in;
         range_ff   <= range_fixed;
         amp_ff     <= amplitude;
      end
      if (cmd.update) begin
         meta_mem[ch_ff] <= {new_idx, new_fill};
         ring_mem[ADDR_W'(base_in + ADDR_W'(cur_idx))] <= '{range_val: range_ff,
                                                           amp_val:   amp_ff};
         count_ff <= new_fill;
         base_ff  <= base_in;
      end
      if (cmd.read) begin
         ring_rd_ff <= ring_mem[ADDR_W'(base_ff + ADDR_W'(slot_ff))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_valid_ff <= '0;
         acc_pend_ff   <= 1'b0;
         slot_ff       <= '0;
      end else begin
         if (cmd.update) chan_valid_ff[ch_ff] <= 1'b1;
         acc_pend_ff <= cmd.read;
         if (cmd.update) begin
            slot_ff <= '0;
         end else if (cmd.read) begin
            slot_ff <= slot_ff + IDX_W'(1);
         end
      end
   end

   // accumulate one slot behind the read
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sum_r_ff <= '0;
         sum_a_ff <= '0;
      end else if (acc_pend_ff) begin
         sum_r_ff <= sum_r_ff + SUM_R_W'(ring_rd_ff.range_val);
         sum_a_ff <= sum_a_ff + SUM_A_W'(ring_rd_ff.amp_val);
      end
   end

   always_comb begin
      recip   = RECIP_TABLE[RECIP_IDX_W'(count_ff - CNT_W'(1))];
      mul_op  = cmd.mul_range ? MUL_IN_W'(sum_r_ff) : MUL_IN_W'(sum_a_ff);
      prod_in = PROD_W'(mul_op) * PROD_W'(recip);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_range || cmd.mul_amp) prod_ff <= prod_in;
      if (cmd.mul_amp) mean_r_ff <= prod_ff[RECIP_SHIFT +: RANGE_W];
      if (cmd.load_out) begin
         rsp_range_ff <= mean_r_ff;
         rsp_amp_ff   <= prod_ff[RECIP_SHIFT +: AMP_W];
         rsp_count_ff <= COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.last_slot = ((CNT_W'(slot_ff) + CNT_W'(1)) == count_ff);
      status.out_busy  = rsp_valid_ff && !rsp_ready;
      rsp_valid        = rsp_valid_ff;
      mean_range       = rsp_range_ff;
      mean_amplitude   = rsp_amp_ff;
      fill_count       = rsp_count_ff;
   end

endmodule

`default_nettype wire

[sv/multichannel_moving_average.sv]
// Multichannel moving average, top level.
// Each item passes through accept, channel update, ring read and sum, two multiplies and output load.
// A new item is accepted only once the previous one has gone into the output register;
// the pace is set by reading the channel's ring slots one per cycle through a single port.
// A result may wait in the output register while the next item is accepted.
// Reset (synchronous, active high) clears all fill counts and write indexes.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_moving_average import mma_pkg::*; #(
   parameter int SENSORS      = 4,
   parameter int MEASUREMENTS = 2,
   parameter int WINDOW       = 5
) (
   input  wire logic clock,
   input  wire logic reset,
   mma_req_if.sink   req_if,
   mma_rsp_if.source rsp_if
);

   mma_cmd_type    cmd;
   mma_status_type status;
   logic           ready;

   mma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   mma_datapath #(
      .SENSORS      (SENSORS),
      .MEASUREMENTS (MEASUREMENTS),
      .WINDOW       (WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .sensor_index      (req_if.sensor_index),
      .measurement_index (req_if.measurement_index),
      .range_fixed       (req_if.range_fixed),
      .amplitude         (req_if.amplitude),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .mean_range        (rsp_if.mean_range),
      .mean_amplitude    (rsp_if.mean_amplitude),
      .fill_count        (rsp_if.fill_count)
   );

   assign req_if.ready = ready;

endmodule

`default_nettype wire

[tb/tb_multichannel_moving_average.sv]
// Self-checking bench for the multichannel moving average block: a short table
// of directed items, then random ones, checked by typed rows or a per-channel window model.
// Depends on mma_pkg and the mma_req_if / mma_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_multichannel_moving_average;
   import mma_pkg::*;

   localparam int SENSORS       = 4;
   localparam int MEASUREMENTS  = 2;
   localparam int WINDOW        = 5;
   localparam int CHANNELS      = SENSORS * MEASUREMENTS;
   localparam int RANDOM_ITEMS  = 1430;
   localparam int CALM_ITEMS    = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int DIRECTED_N    = 21;

   typedef struct packed {
      logic [RANGE_W-1:0] mean_range;
      logic [AMP_W-1:0]   mean_amplitude;
      logic [COUNT_W-1:0] fill_count;
   } average_type;

   typedef struct packed {
      logic [SENSOR_W-1:0] sensor;
      logic [MEAS_W-1:0]   meas;
      logic [RANGE_W-1:0]  range_in;
      logic [AMP_W-1:0]    amp_in;
      logic                typed;
      average_type         want;
   } stim_row_type;

   // Rows marked typed carry their result; the rest go through the window model.
   localparam stim_row_type DIRECTED_ROWS [0:DIRECTED_N-1] = '{
      '{2'd0, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd1}},
      '{2'd0, 1'b0, 18'h00000, 16'h0000, 1'b1, '{18'h1FFFF, 16'h7FFF, 3'd2}},
      '{2'd3, 1'b1, 18'h00000, 16'h0000, 1'b1, '{18'h00000, 16'h0000, 3'd1}},
      '{2'd3, 1'b1, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h1FFFF, 16'h7FFF, 3'd2}},
      '{2'd0, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b0, '{18'h0, 16'h0, 3'd0}},
      '{2'd0, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b0, '{18'h0, 16'h0, 3'd0}},
      '{2'd0, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b0, '{18'h0, 16'h0, 3'd0}},
      // window full: overwrite the oldest slot
      '{2'd0, 1'b0, 18'h00000, 16'h0000, 1'b0, '{18'h0, 16'h0, 3'd0}},
      '{2'd0, 1'b0, 18'h00001, 16'h0001, 1'b0, '{18'h0, 16'h0, 3'd0}},
      '{2'd1, 1'b0, 18'h2AAAA, 16'hAAAA, 1'b1, '{18'h2AAAA, 16'hAAAA, 3'd1}},
      '{2'd1, 1'b1, 18'h15555, 16'h5555, 1'b1, '{18'h15555, 16'h5555, 3'd1}},
      '{2'd2, 1'b0, 18'h00001, 16'h0001, 1'b1, '{18'h00001, 16'h0001, 3'd1}},
      // odd sums: means truncate
      '{2'd2, 1'b0, 18'h00002, 16'h0000, 1'b0, '{18'h0, 16'h0, 3'd0}},
      '{2'd2, 1'b1, 18'h3FFFE, 16'hFFFE, 1'b1, '{18'h3FFFE, 16'hFFFE, 3'd1}},
      '{2'd0, 1'b1, 18'h12345, 16'h1234, 1'b1, '{18'h12345, 16'h1234, 3'd1}},
      '{2'd3, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd1}},
      '{2'd3, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd2}},
      '{2'd3, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd3}},
      '{2'd3, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd4}},
      '{2'd3, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd5}},
      // fill count saturates
      '{2'd3, 1'b0, 18'h3FFFF, 16'hFFFF, 1'b1, '{18'h3FFFF, 16'hFFFF, 3'd5}}
   };

   logic clock = 1'b0;
   logic reset;

   mma_req_if req_ch ();
   mma_rsp_if rsp_ch ();

   multichannel_moving_average #(
      .SENSORS      (SENSORS),
      .MEASUREMENTS (MEASUREMENTS),
      .WINDOW       (WINDOW)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [RANGE_W-1:0] range_ring [CHANNELS][WINDOW];
   logic [AMP_W-1:0]   amp_ring   [CHANNELS][WINDOW];
   int                 ring_pos   [CHANNELS];
   int                 ring_fill  [CHANNELS];

   average_type expected_means [$];
   logic        item_typed;
   average_type item_want;
   bit          calm;
   int          errors;
   int          stall_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns  MISMATCH  %s", $time, what);
      errors++;
   endtask

   // Store the sample in its channel's ring and return the truncated means.
   function automatic average_type advance_window(
      input logic [SENSOR_W-1:0] sensor,
      input logic [MEAS_W-1:0]   meas,
      input logic [RANGE_W-1:0]  range_in,
      input logic [AMP_W-1:0]    amp_in
   );
      int          chan;
      int          slot;
      int unsigned range_sum;
      int unsigned amp_sum;
      average_type mean;
      chan = (int'(sensor) % SENSORS) * MEASUREMENTS + int'(meas) % MEASUREMENTS;
      slot = ring_pos[chan];
      range_ring[chan][slot] = range_in;
      amp_ring[chan][slot]   = amp_in;
      ring_pos[chan] = (slot + 1) % WINDOW;
      if (ring_fill[chan] < WINDOW) begin
         ring_fill[chan]++;
      end
      range_sum = 0;
      amp_sum   = 0;
      for (int i = 0; i < ring_fill[chan]; i++) begin
         range_sum += range_ring[chan][i];
         amp_sum   += amp_ring[chan][i];
      end
      mean.mean_range     = RANGE_W'(range_sum / ring_fill[chan]);
      mean.mean_amplitude = AMP_W'(amp_sum / ring_fill[chan]);
      mean.fill_count     = COUNT_W'(ring_fill[chan]);
      return mean;
   endfunction

   task automatic send_item(
      input logic [SENSOR_W-1:0] sensor,
      input logic [MEAS_W-1:0]   meas,
      input logic [RANGE_W-1:0]  range_in,
      input logic [AMP_W-1:0]    amp_in,
      input logic                typed,
      input average_type         want
   );
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.sensor_index      <= sensor;
      req_ch.measurement_index <= meas;
      req_ch.range_fixed       <= range_in;
      req_ch.amplitude         <= amp_in;
      item_typed               <= typed;
      item_want                <= want;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // Extremes show up often; otherwise any value.
   function automatic logic [RANGE_W-1:0] pick_range();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return RANGE_W'($urandom);
      endcase
   endfunction

   function automatic logic [AMP_W-1:0] pick_amp();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return AMP_W'($urandom);
      endcase
   endfunction

   // Predict at the accepting edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         average_type mean;
         mean = advance_window(req_ch.sensor_index, req_ch.measurement_index,
                               req_ch.range_fixed, req_ch.amplitude);
         expected_means.push_back(item_typed ? item_want : mean);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         average_type want;
         if (expected_means.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_means.pop_front();
            if (rsp_ch.mean_range !== want.mean_range)
               report_mismatch($sformatf("mean_range %h, want %h",
                                         rsp_ch.mean_range, want.mean_range));
            if (rsp_ch.mean_amplitude !== want.mean_amplitude)
               report_mismatch($sformatf("mean_amplitude %h, want %h",
                                         rsp_ch.mean_amplitude, want.mean_amplitude));
            if (rsp_ch.fill_count !== want.fill_count)
               report_mismatch($sformatf("fill_count %0d, want %0d",
                                         rsp_ch.fill_count, want.fill_count));
         end
      end
   end

   // Watchdog: no item moving on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_multichannel_moving_average NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side back-pressure.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   initial begin
      logic [SENSOR_W-1:0] sensor;
      logic [MEAS_W-1:0]   meas;
      errors       = 0;
      calm         = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         ring_pos[c]  = 0;
         ring_fill[c] = 0;
      end
      reset                    <= 1'b1;
      req_ch.valid             <= 1'b0;
      req_ch.sensor_index      <= '0;
      req_ch.measurement_index <= '0;
      req_ch.range_fixed       <= '0;
      req_ch.amplitude         <= '0;
      item_typed               <= 1'b0;
      item_want                <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_N; r++) begin
         send_item(DIRECTED_ROWS[r].sensor, DIRECTED_ROWS[r].meas, DIRECTED_ROWS[r].range_in,
                   DIRECTED_ROWS[r].amp_in, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end

      sensor = '0;
      meas   = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         // stay on one channel for a while half the time, so windows wrap often
         if ($urandom_range(0, 1) == 0) begin
            sensor = SENSOR_W'($urandom);
            meas   = MEAS_W'($urandom);
         end
         send_item(sensor, meas, pick_range(), pick_amp(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_multichannel_moving_average OK");
      end else begin
         $display("tb_multichannel_moving_average NOT OK");
      end
      $finish;
   end

endmodule
